@@ design/pse_pkg.sv @@
// ----------------------------------------------------------------------------
// pse_pkg
// Types, constants and byte helpers shared by the PNG stored-stream encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pse_pkg;

  localparam int unsigned DimW     = 15;
  localparam int unsigned MaxDim   = 16384;
  localparam int unsigned RawW     = 30;
  localparam int unsigned BlkBytes = 65535;
  localparam logic [16:0] AdlerMod = 17'd65521;
  localparam logic [31:0] CrcPoly  = 32'hEDB88320;
  localparam logic [31:0] AllOnes  = 32'hFFFFFFFF;

  // Command codes of an input transaction
  localparam logic CmdStart = 1'b0;
  localparam logic CmdPixel = 1'b1;

  // Configuration register indexes
  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       run_last;
    logic       file_end;
  } out_item_t;

  // Control of the shared checksum unit
  typedef struct packed {
    logic init_crc;
    logic init_adler;
    logic upd_crc;
    logic upd_adler;
  } sum_ctl_t;

  // One byte through the reflected CRC-32
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? (CrcPoly ^ (r >> 1)) : (r >> 1);
    end
    return r;
  endfunction

  // Big-endian byte sel of a 32-bit word
  function automatic logic [7:0] be_byte(input logic [31:0] x, input logic [1:0] sel);
    logic [7:0] r;
    unique case (sel)
      2'd0:    r = x[31:24];
      2'd1:    r = x[23:16];
      2'd2:    r = x[15:8];
      default: r = x[7:0];
    endcase
    return r;
  endfunction

  // Fixed bytes of the preamble (variable positions read as zero)
  function automatic logic [7:0] pre_const(input logic [5:0] idx);
    logic [7:0] r;
    case (idx)
      6'd0:  r = 8'h89;
      6'd1:  r = 8'h50;
      6'd2:  r = 8'h4E;
      6'd3:  r = 8'h47;
      6'd4:  r = 8'h0D;
      6'd5:  r = 8'h0A;
      6'd6:  r = 8'h1A;
      6'd7:  r = 8'h0A;
      6'd11: r = 8'h0D;
      6'd12: r = 8'h49;
      6'd13: r = 8'h48;
      6'd14: r = 8'h44;
      6'd15: r = 8'h52;
      6'd24: r = 8'h08;
      6'd25: r = 8'h02;
      6'd37: r = 8'h49;
      6'd38: r = 8'h44;
      6'd39: r = 8'h41;
      6'd40: r = 8'h54;
      6'd41: r = 8'h78;
      6'd42: r = 8'h01;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // IEND type and its CRC
  function automatic logic [7:0] iend_byte(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0: r = 8'h49;
      3'd1: r = 8'h45;
      3'd2: r = 8'h4E;
      3'd3: r = 8'h44;
      3'd4: r = 8'hAE;
      3'd5: r = 8'h42;
      3'd6: r = 8'h60;
      3'd7: r = 8'h82;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/pse_size_calc.sv @@
// ----------------------------------------------------------------------------
// pse_size_calc
// Raw IDAT byte count and IDAT chunk length from the image size, in three
// registered steps: multiply, block count, length sum.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_size_calc (
  input  wire logic                     clk,
  input  wire logic [pse_pkg::DimW-1:0] image_width,
  input  wire logic [pse_pkg::DimW-1:0] image_height,
  output logic      [pse_pkg::RawW-1:0] raw_bytes,
  output logic      [31:0]              idat_len
);
  import pse_pkg::*;

  logic [15:0] row_bytes;
  logic [30:0] product;
  logic [16:0] split_sum;
  logic        ge_blk;
  logic [16:0] rem;
  logic [14:0] nblk_next;
  logic [14:0] nblk;
  logic [RawW-1:0] raw_d;

  // Bytes per row: filter byte plus three per pixel
  assign row_bytes = 16'd1 + 16'(3 * 17'(image_width));
  assign product   = 31'(image_height) * 31'(row_bytes);

  // Divide by 65535: x = a*65535 + (a + b)
  assign split_sum = 17'(raw_bytes[RawW-1:16]) + 17'(raw_bytes[15:0]);
  assign ge_blk    = split_sum >= 17'(BlkBytes);
  assign rem       = ge_blk ? split_sum - 17'(BlkBytes) : split_sum;
  assign nblk_next = 15'(raw_bytes[RawW-1:16]) + 15'(ge_blk) + 15'(rem != 17'd0);

  // Free-running pipeline; a register write settles through the registered steps
  always_ff @(posedge clk) begin
    raw_bytes <= product[RawW-1:0];
    nblk      <= nblk_next;
    raw_d     <= raw_bytes;
    idat_len  <= 32'(raw_d) + 32'(5 * 18'(nblk)) + 32'd6;
  end

endmodule

`default_nettype wire

@@ design/pse_checksum.sv @@
// ----------------------------------------------------------------------------
// pse_checksum
// Shared byte-serial CRC-32 and Adler-32 unit, one byte a cycle on update.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_checksum (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pse_pkg::sum_ctl_t ctl,
  input  wire logic [7:0]        data,
  output logic      [31:0]       crc,
  output logic      [15:0]       adler_low,
  output logic      [15:0]       adler_high
);
  import pse_pkg::*;

  logic [16:0] lo_sum;
  logic [16:0] lo_red;
  logic [16:0] hi_sum;
  logic [16:0] hi_red;

  // Adler sums modulo 65521
  assign lo_sum = 17'(adler_low) + 17'(data);
  assign lo_red = (lo_sum >= AdlerMod) ? lo_sum - AdlerMod : lo_sum;
  assign hi_sum = 17'(adler_high) + lo_red;
  assign hi_red = (hi_sum >= AdlerMod) ? hi_sum - AdlerMod : hi_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc        <= AllOnes;
      adler_low  <= 16'd1;
      adler_high <= 16'd0;
    end else begin
      // Restart or advance the CRC
      if (ctl.init_crc) begin
        crc <= AllOnes;
      end else if (ctl.upd_crc) begin
        crc <= crc_byte(crc, data);
      end
      // Restart or advance Adler-32
      if (ctl.init_adler) begin
        adler_low  <= 16'd1;
        adler_high <= 16'd0;
      end else if (ctl.upd_adler) begin
        adler_low  <= lo_red[15:0];
        adler_high <= hi_red[15:0];
      end
    end
  end

endmodule

`default_nettype wire

@@ design/png_stored_stream_encoder.sv @@
// ----------------------------------------------------------------------------
// png_stored_stream_encoder
// Streams an 8-bit RGB PNG file built from stored deflate blocks.
// ----------------------------------------------------------------------------
// Usage: set image_width and image_height through the write port while no
// frame is open. A start transaction (command 0) produces the 43-byte
// preamble; each pixel transaction (command 1) produces its R, G, B bytes,
// preceded by a filter byte at the start of a row and by a 5-byte block
// header wherever a stored block begins. The last pixel also produces the
// 20-byte trailer (Adler-32, IDAT CRC, IEND). run_last flags the final byte
// of each transaction, file_end the final byte of the file.
// Timing: one output byte per cycle while out_ready is high. The first byte
// of a transaction passes the state register, then the output register. A
// pixel runs from idle through its 3 or 4 bytes, after a block header where
// a stored block opens and before the trailer at the last pixel; a start
// runs through the preamble. in_ready is high only while the sequencer is
// idle. One output register sits between the sequencer and out_*; a
// stalled receiver holds the sequencer with no byte lost.
// Reset returns to idle with 1 x 1 image size and no frame open.
// ----------------------------------------------------------------------------
`default_nettype none

module png_stored_stream_encoder (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic                     cfg_index,
  input  wire logic [pse_pkg::DimW-1:0] cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire pse_pkg::in_item_t        in_item,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output pse_pkg::out_item_t            out_item
);
  import pse_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PRE  = 5'b00010,
    ST_PIX  = 5'b00100,
    ST_HDR  = 5'b01000,
    ST_TRL  = 5'b10000
  } state_t;

  state_t          state;
  logic [5:0]      idx;
  logic [1:0]      raw_idx;
  logic [DimW-1:0] image_width;
  logic [DimW-1:0] image_height;
  logic            frame_active;
  logic [13:0]     column_count;
  logic [13:0]     row_count;
  logic [RawW-1:0] raw_bytes_left;
  logic [15:0]     block_bytes_left;
  logic [7:0]      red;
  logic [7:0]      green;
  logic [7:0]      blue;

  logic [RawW-1:0] raw_bytes;
  logic [31:0]     idat_len;
  logic [31:0]     crc;
  logic [15:0]     adler_low;
  logic [15:0]     adler_high;
  sum_ctl_t        ctl;

  logic            in_accept;
  logic            emit;
  logic [7:0]      data;
  logic            last_raw;
  logic            row_done;
  logic            frame_done;
  logic [DimW-1:0] dim_clamped;
  logic [5:0]      idx_m1;
  logic [15:0]     blk_len;
  logic [15:0]     blk_nlen;
  logic            blk_final;
  logic [7:0]      raw_val;

  pse_size_calc u_size (
    .clk          (clk),
    .image_width  (image_width),
    .image_height (image_height),
    .raw_bytes    (raw_bytes),
    .idat_len     (idat_len)
  );

  pse_checksum u_sum (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .data       (data),
    .crc        (crc),
    .adler_low  (adler_low),
    .adler_high (adler_high)
  );

  assign in_ready  = (state == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  // Advance only when the output register is free or being drained
  assign emit = (state == ST_PRE || state == ST_HDR || state == ST_TRL
                 || (state == ST_PIX && block_bytes_left != 16'd0))
                && (!out_valid || out_ready);

  assign idx_m1    = idx - 6'd1;
  assign blk_final = raw_bytes_left <= RawW'(BlkBytes);
  assign blk_len   = blk_final ? raw_bytes_left[15:0] : 16'(BlkBytes);
  assign blk_nlen  = ~blk_len;
  assign last_raw  = (raw_idx == 2'd3);
  assign row_done  = (15'(column_count) + 15'd1) >= image_width;
  assign frame_done = row_done && ((15'(row_count) + 15'd1) >= image_height);

  // Clamp a written dimension into 1 .. MaxDim
  always_comb begin
    if (cfg_data == '0) begin
      dim_clamped = DimW'(1);
    end else if (cfg_data > DimW'(MaxDim)) begin
      dim_clamped = DimW'(MaxDim);
    end else begin
      dim_clamped = cfg_data;
    end
  end

  // Select the raw byte of the pixel
  always_comb begin
    unique case (raw_idx)
      2'd0:    raw_val = 8'h00;
      2'd1:    raw_val = red;
      2'd2:    raw_val = green;
      default: raw_val = blue;
    endcase
  end

  // Build the outgoing byte and the checksum control
  always_comb begin
    data = 8'h00;
    ctl  = '0;
    unique case (state)
      ST_PRE: begin
        if (idx >= 6'd16 && idx <= 6'd19) begin
          data = be_byte(32'(image_width), idx[1:0]);
        end else if (idx >= 6'd20 && idx <= 6'd23) begin
          data = be_byte(32'(image_height), idx[1:0]);
        end else if (idx >= 6'd29 && idx <= 6'd32) begin
          data = be_byte(~crc, idx_m1[1:0]);
        end else if (idx >= 6'd33 && idx <= 6'd36) begin
          data = be_byte(idat_len, idx_m1[1:0]);
        end else begin
          data = pre_const(idx);
        end
        ctl.upd_crc  = emit && ((idx >= 6'd12 && idx <= 6'd28) || idx >= 6'd37);
        ctl.init_crc = emit && (idx == 6'd32);
      end
      ST_HDR: begin
        unique case (idx[2:0])
          3'd0:    data = {7'd0, blk_final};
          3'd1:    data = blk_len[7:0];
          3'd2:    data = blk_len[15:8];
          3'd3:    data = blk_nlen[7:0];
          default: data = blk_nlen[15:8];
        endcase
        ctl.upd_crc = emit;
      end
      ST_PIX: begin
        data          = raw_val;
        ctl.upd_crc   = emit;
        ctl.upd_adler = emit;
      end
      ST_TRL: begin
        if (idx < 6'd4) begin
          data        = be_byte({adler_high, adler_low}, idx[1:0]);
          ctl.upd_crc = emit;
        end else if (idx < 6'd8) begin
          data = be_byte(~crc, idx[1:0]);
        end else if (idx < 6'd12) begin
          data = 8'h00;
        end else begin
          // Positions 12 to 19 map onto IEND bytes 0 to 7
          data = iend_byte(idx[2:0] + 3'd4);
        end
      end
      default: begin
        ctl.init_crc   = in_accept && (in_item.command == CmdStart);
        ctl.init_adler = in_accept && (in_item.command == CmdStart);
      end
    endcase
  end

  // Configuration registers, frozen while a frame is open
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DimW'(1);
      image_height <= DimW'(1);
    end else if (cfg_we && !frame_active) begin
      if (cfg_index == RegWidth) begin
        image_width <= dim_clamped;
      end else begin
        image_height <= dim_clamped;
      end
    end
  end

  // Hold the pixel components of the transaction
  always_ff @(posedge clk) begin
    if (in_accept) begin
      red   <= in_item.red;
      green <= in_item.green;
      blue  <= in_item.blue;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      idx              <= '0;
      raw_idx          <= '0;
      frame_active     <= 1'b0;
      column_count     <= '0;
      row_count        <= '0;
      raw_bytes_left   <= '0;
      block_bytes_left <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            if (in_item.command == CmdStart) begin
              state            <= ST_PRE;
              idx              <= '0;
              frame_active     <= 1'b1;
              column_count     <= '0;
              row_count        <= '0;
              block_bytes_left <= '0;
            end else if (frame_active) begin
              state   <= ST_PIX;
              raw_idx <= (column_count == 14'd0) ? 2'd0 : 2'd1;
            end
          end
        end
        ST_PRE: begin
          if (emit) begin
            idx <= idx + 6'd1;
            if (idx == 6'd42) begin
              state          <= ST_IDLE;
              raw_bytes_left <= raw_bytes;
            end
          end
        end
        ST_HDR: begin
          if (emit) begin
            idx <= idx + 6'd1;
            if (idx == 6'd4) begin
              state            <= ST_PIX;
              block_bytes_left <= blk_len;
            end
          end
        end
        ST_PIX: begin
          if (block_bytes_left == 16'd0) begin
            // Open a new stored block first
            state <= ST_HDR;
            idx   <= '0;
          end else if (emit) begin
            block_bytes_left <= block_bytes_left - 16'd1;
            if (raw_bytes_left != '0) begin
              raw_bytes_left <= raw_bytes_left - RawW'(1);
            end
            raw_idx <= raw_idx + 2'd1;
            if (last_raw) begin
              if (frame_done) begin
                state        <= ST_TRL;
                idx          <= '0;
                frame_active <= 1'b0;
                column_count <= '0;
                row_count    <= '0;
              end else begin
                if (row_done) begin
                  column_count <= '0;
                  row_count    <= row_count + 14'd1;
                end else begin
                  column_count <= column_count + 14'd1;
                end
                state <= ST_IDLE;
              end
            end
          end
        end
        ST_TRL: begin
          if (emit) begin
            idx <= idx + 6'd1;
            if (idx == 6'd19) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item.data_byte <= data;
      out_item.run_last  <= (state == ST_PRE && idx == 6'd42)
                            || (state == ST_PIX && last_raw && !frame_done)
                            || (state == ST_TRL && idx == 6'd19);
      out_item.file_end  <= (state == ST_TRL && idx == 6'd19);
    end
  end

endmodule

`default_nettype wire

@@ bench/tb_png_stored_stream_encoder.sv @@
// ----------------------------------------------------------------------------
// tb_png_stored_stream_encoder
// Checks the PNG byte stream of the encoder against a predictor of its own.
// Directed frames cover the size extremes and the odd cases: a start during a
// frame, stray pixels, writes during a frame. Random frames of small sizes
// follow, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_png_stored_stream_encoder;
  import pse_pkg::*;

  // Predictor and store of expected bytes
  class png_byte_scoreboard;
    int unsigned width_cfg, height_cfg;
    bit          in_frame;
    int unsigned col, row;
    int unsigned raw_left, blk_left;
    logic [31:0] adl_lo, adl_hi, idat_crc;
    out_item_t   bytes_due[$];
    int          errors;
    int          checked;

    function void clear();
      width_cfg = 1;
      height_cfg = 1;
      in_frame = 0;
      col = 0;
      row = 0;
      raw_left = 0;
      blk_left = 0;
      adl_lo = 1;
      adl_hi = 0;
      idat_crc = 32'hFFFFFFFF;
      bytes_due.delete();
      errors = 0;
      checked = 0;
    endfunction

    function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) r = r[0] ? (32'hEDB88320 ^ (r >> 1)) : (r >> 1);
      return r;
    endfunction

    function void push(logic [7:0] b);
      out_item_t o;
      o.data_byte = b;
      o.run_last = 1'b0;
      o.file_end = 1'b0;
      bytes_due = {bytes_due, o};
    endfunction

    function void push_idat(logic [7:0] b);
      idat_crc = crc_step(idat_crc, b);
      push(b);
    endfunction

    function void push_word(logic [31:0] w, bit to_crc);
      for (int s = 24; s >= 0; s -= 8)
        if (to_crc) push_idat(w[s+:8]);
        else push(w[s+:8]);
    endfunction

    function void write_reg(logic idx, logic [14:0] v);
      int unsigned d;
      if (in_frame) return;
      d = (v == 0) ? 1 : (v > MaxDim ? MaxDim : v);
      if (idx == RegWidth) width_cfg = d;
      else height_cfg = d;
    endfunction

    // Raw zlib byte: opens a stored block where one is due
    function void push_raw(logic [7:0] v);
      int unsigned len;
      if (blk_left == 0) begin
        len = raw_left < BlkBytes ? raw_left : BlkBytes;
        push_idat(raw_left <= BlkBytes ? 8'd1 : 8'd0);
        push_idat(len[7:0]);
        push_idat(len[15:8]);
        push_idat(~len[7:0]);
        push_idat(~len[15:8]);
        blk_left = len;
      end
      push_idat(v);
      adl_lo = adl_lo + v;
      if (adl_lo >= 65521) adl_lo -= 65521;
      adl_hi = adl_hi + adl_lo;
      if (adl_hi >= 65521) adl_hi -= 65521;
      if (blk_left != 0) blk_left--;
      if (raw_left != 0) raw_left--;
    endfunction

    function void note_input(in_item_t it);
      int          first;
      logic [31:0] c;
      logic [63:0] raw, nblk;
      logic [7:0]  hdr[17];
      logic [7:0]  iend[4];
      first = bytes_due.size();
      if (it.command == CmdStart) begin
        hdr = '{8'h49, 8'h48, 8'h44, 8'h52, 0, 0, 0, 0, 0, 0, 0, 0, 8, 2, 0, 0, 0};
        {hdr[4], hdr[5], hdr[6], hdr[7]} = width_cfg;
        {hdr[8], hdr[9], hdr[10], hdr[11]} = height_cfg;
        push(8'h89); push(8'h50); push(8'h4E); push(8'h47);
        push(8'h0D); push(8'h0A); push(8'h1A); push(8'h0A);
        push_word(32'd13, 0);
        c = 32'hFFFFFFFF;
        for (int i = 0; i < 17; i++) begin
          push(hdr[i]);
          c = crc_step(c, hdr[i]);
        end
        push_word(~c, 0);
        raw = 64'(height_cfg) * (1 + 3 * 64'(width_cfg));
        nblk = (raw + BlkBytes - 1) / BlkBytes;
        push_word(32'(2 + raw + 5 * nblk + 4), 0);
        idat_crc = 32'hFFFFFFFF;
        push_idat(8'h49); push_idat(8'h44); push_idat(8'h41); push_idat(8'h54);
        push_idat(8'h78); push_idat(8'h01);
        in_frame = 1;
        col = 0;
        row = 0;
        raw_left = 32'(raw);
        blk_left = 0;
        adl_lo = 1;
        adl_hi = 0;
      end else if (in_frame) begin
        if (col == 0) push_raw(8'h00);
        push_raw(it.red);
        push_raw(it.green);
        push_raw(it.blue);
        col++;
        if (col >= width_cfg) begin
          col = 0;
          row++;
          if (row >= height_cfg) begin
            push_word({adl_hi[15:0], adl_lo[15:0]}, 1);
            push_word(~idat_crc, 0);
            push_word(32'd0, 0);
            iend = '{8'h49, 8'h45, 8'h4E, 8'h44};
            c = 32'hFFFFFFFF;
            for (int i = 0; i < 4; i++) begin
              push(iend[i]);
              c = crc_step(c, iend[i]);
            end
            push_word(~c, 0);
            bytes_due[$].file_end = 1'b1;
            in_frame = 0;
            row = 0;
          end
        end
      end
      if (bytes_due.size() > first) bytes_due[$].run_last = 1'b1;
    endfunction

    function void check_output(out_item_t got);
      out_item_t want;
      checked++;
      if (bytes_due.size() == 0) begin
        $display("%0t: unexpected byte, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = bytes_due.pop_front();
      if (got.data_byte !== want.data_byte) begin
        $display("%0t: data_byte expected %h actual %h", $time, want.data_byte,
                 got.data_byte);
        errors++;
      end
      if (got.run_last !== want.run_last) begin
        $display("%0t: run_last expected %b actual %b", $time, want.run_last, got.run_last);
        errors++;
      end
      if (got.file_end !== want.file_end) begin
        $display("%0t: file_end expected %b actual %b", $time, want.file_end, got.file_end);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic        cfg_index = 0;
  logic [14:0] cfg_data = '0;
  logic        in_valid = 0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 0;
  out_item_t   out_item;

  png_byte_scoreboard png_sb;
  bit  hold_off_go = 0;
  int  hold_off_cycles = 0;
  int  frames_sent = 0;
  bit  rx_chaos = 0;

  png_stored_stream_encoder dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  always #5 clk = ~clk;

  // Check every accepted output transaction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) png_sb.check_output(out_item);
  end

  // Receiver: one long hold-off once asked, else random stalls or always ready
  always @(posedge clk) begin
    if (hold_off_go && hold_off_cycles < 400) begin
      hold_off_cycles <= hold_off_cycles + 1;
      out_ready <= 1'b0;
    end else if (rx_chaos) begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Offer one input transaction and hold it until accepted
  task automatic send_item(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    in_item_t it;
    it.command = cmd;
    it.red = r;
    it.green = g;
    it.blue = b;
    in_item <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    png_sb.note_input(it);
    if ($urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_pixel();
    send_item(CmdPixel, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Wait for the stream to drain, then let the sequencer settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (png_sb.bytes_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [14:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    png_sb.write_reg(idx, v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_frame(int unsigned w, int unsigned h);
    write_reg(RegWidth, 15'(w));
    write_reg(RegHeight, 15'(h));
    send_item(CmdStart, 8'($urandom), 8'($urandom), 8'($urandom));
    for (int i = 0; i < png_sb.width_cfg * png_sb.height_cfg; i++) send_pixel();
    frames_sent++;
    drain();
  endtask

  initial begin
    png_sb = new();
    png_sb.clear();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset size, extremes of colour, stray pixels
    send_item(CmdPixel, 8'hFF, 8'hFF, 8'hFF);
    send_item(CmdStart, 0, 0, 0);
    send_item(CmdPixel, 8'hFF, 8'h00, 8'hAA);
    send_item(CmdPixel, 8'h55, 8'h55, 8'h55);
    drain();
    write_reg(RegWidth, 15'd2);
    send_item(CmdStart, 0, 0, 0);
    send_pixel();
    drain();
    run_frame(2, 2);

    // Hold off the receiver so the block backs up into its input
    hold_off_go = 1;
    run_frame(3, 2);

    rx_chaos = 1;
    for (int n = 0; n < 14; n++) begin
      if ($urandom_range(0, 5) == 0) begin
        write_reg(RegWidth, 15'($urandom_range(1, 3)));
        send_item(CmdStart, 0, 0, 0);
        repeat ($urandom_range(0, 2)) send_pixel();
        send_pixel();
        drain();
      end
      run_frame($urandom_range(1, 4), $urandom_range(1, 3));
    end
    // One frame of a single 30-pixel row, held in one stored block
    run_frame(30, 1);
    rx_chaos = 0;
    drain();

    // Zero and oversize dimensions are clamped; the huge frame stays open
    write_reg(RegWidth, 15'd0);
    write_reg(RegHeight, 15'h7FFF);
    send_item(CmdStart, 0, 0, 0);
    drain();
    // Write during a frame is dropped; start restarts the frame
    write_reg(RegWidth, 15'd16384);
    write_reg(RegHeight, 15'd16384);
    send_item(CmdStart, 0, 0, 0);
    send_item(CmdPixel, 8'h00, 8'hFF, 8'h00);
    drain();

    $display("Ran %0d frames, %0d bytes checked, with bursts, stalls and a long hold-off.",
             frames_sent, png_sb.checked);
    if (png_sb.errors == 0 && png_sb.bytes_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
